// ----- rtl/core/msa_pkg.sv -----
// Shared codes for the max-spacing seat allocator.
// Holds the request kinds and result status codes; no dependencies.
package msa_pkg;

	typedef logic [1:0] status_t;

	localparam logic    KIND_TAKE      = 1'b0;
	localparam logic    KIND_RELEASE   = 1'b1;

	localparam status_t STATUS_OK      = 2'd0;
	localparam status_t STATUS_FULL    = 2'd1;
	localparam status_t STATUS_WAS_FREE = 2'd2;

endpackage

// ----- rtl/core/max_spacing_seat_allocator.sv -----
// Top level of the max-spacing seat allocator.
// Keeps the sorted occupied-slot list in one synchronous memory.
// Depends on msa_pkg.
//
// Each request is handled alone. A release scans the whole occupied list once and compacts
// it in the same pass. A take scans the list once to find the widest spacing and then
// shifts the entries above the chosen position up by one. The list memory has a single
// read and a single write port. A finished result waits in the output register while the
// next request is accepted. No clearing pass runs after reset.
module max_spacing_seat_allocator
	import msa_pkg::*;
#(
	parameter int MAX_SLOTS = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       kind,
	input  logic [7:0] slot,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] chosen_slot,
	output status_t    status,
	input  logic       cfg_wr_en,
	input  logic [8:0] cfg_wr_data
);

	localparam int AW    = $clog2(MAX_SLOTS);
	localparam int CW    = $clog2(MAX_SLOTS + 1);
	localparam int CMPW  = (AW > 8) ? AW : 8;
	localparam int RST_N = (256 > MAX_SLOTS) ? MAX_SLOTS : 256;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_RESP
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   n_q;
	logic [CW-1:0]   count_q;
	logic            kind_q;
	logic [7:0]      slot_q;
	logic [CW-1:0]   rd_idx_q;
	logic            rv_s1;
	logic [CW-1:0]   ridx_s1;
	logic [AW-1:0]   rdata_s1;
	logic            have_q;
	logic            found_q;
	logic [AW-1:0]   last_q;
	logic [AW-1:0]   best_q;
	logic [AW-1:0]   pick_q;
	logic [CW-1:0]   pos_q;
	logic [CW-1:0]   eff_q;
	status_t         res_status_q;

	logic [AW-1:0]   mem [MAX_SLOTS];

	logic            rd_en;
	logic [CW-1:0]   rd_tag;
	logic [CW-1:0]   rd_dec;
	logic            mem_we;
	logic [CW-1:0]   wr_idx;
	logic [AW-1:0]   wr_data;
	logic            in_row;
	logic [AW-1:0]   diff;
	logic [AW-1:0]   gap;
	logic [AW:0]     mid_sum;
	logic [CW-1:0]   tail_full;
	logic [AW-1:0]   tail;
	logic [CW-1:0]   nm1;
	logic            scan_done;
	logic [CW-1:0]   n_clamped;

	assign in_ready  = (state_q == ST_IDLE);
	assign rd_dec    = rd_idx_q - CW'(1);
	assign in_row    = CW'(rdata_s1) < n_q;
	assign diff      = rdata_s1 - last_q;
	assign gap       = diff >> 1;
	assign mid_sum   = {1'b0, last_q} + {1'b0, rdata_s1};
	assign nm1       = n_q - CW'(1);
	assign tail_full = nm1 - CW'(last_q);
	assign tail      = tail_full[AW-1:0];
	assign scan_done = !rd_en && !rv_s1;

	always_comb begin
		if (cfg_wr_data == 9'd0) begin
			n_clamped = CW'(1);
		end else if (32'(cfg_wr_data) > 32'(MAX_SLOTS)) begin
			n_clamped = CW'(MAX_SLOTS);
		end else begin
			n_clamped = CW'(cfg_wr_data);
		end
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_tag  = rd_idx_q;
		mem_we  = 1'b0;
		wr_idx  = ridx_s1;
		wr_data = rdata_s1;
		case (state_q)
			ST_SCAN: begin
				rd_en  = (rd_idx_q != count_q);
				rd_tag = rd_idx_q;
				if (rv_s1 && kind_q == KIND_RELEASE && found_q) begin
					mem_we = 1'b1;
					wr_idx = ridx_s1 - CW'(1);
				end
			end
			ST_SHIFT: begin
				rd_en  = (rd_idx_q != pos_q);
				rd_tag = rd_dec;
				if (rv_s1) begin
					mem_we = 1'b1;
					wr_idx = ridx_s1 + CW'(1);
				end else if (!rd_en) begin
					mem_we  = 1'b1;
					wr_idx  = pos_q;
					wr_data = pick_q;
				end
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_idx[AW-1:0]] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_tag[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= CW'(RST_N);
		end else if (cfg_wr_en) begin
			n_q <= n_clamped;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			kind_q       <= KIND_TAKE;
			slot_q       <= '0;
			rd_idx_q     <= '0;
			rv_s1        <= 1'b0;
			ridx_s1      <= '0;
			have_q       <= 1'b0;
			found_q      <= 1'b0;
			last_q       <= '0;
			best_q       <= '0;
			pick_q       <= '0;
			pos_q        <= '0;
			eff_q        <= '0;
			res_status_q <= STATUS_OK;
			out_valid    <= 1'b0;
			chosen_slot  <= '0;
			status       <= STATUS_OK;
		end else begin
			rv_s1   <= rd_en;
			ridx_s1 <= rd_tag;
			if (out_valid && out_ready && state_q != ST_RESP) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						kind_q   <= kind;
						slot_q   <= slot;
						rd_idx_q <= '0;
						have_q   <= 1'b0;
						found_q  <= 1'b0;
						last_q   <= '0;
						best_q   <= '0;
						pick_q   <= '0;
						pos_q    <= '0;
						eff_q    <= '0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						rd_idx_q <= rd_idx_q + CW'(1);
					end
					if (rv_s1) begin
						if (kind_q == KIND_RELEASE) begin
							if (!found_q && CMPW'(rdata_s1) == CMPW'(slot_q)) begin
								found_q <= 1'b1;
							end
						end else if (in_row) begin
							if (!have_q) begin
								have_q <= 1'b1;
								best_q <= rdata_s1;
								pick_q <= '0;
								pos_q  <= '0;
							end else if (gap > best_q) begin
								best_q <= gap;
								pick_q <= mid_sum[AW:1];
								pos_q  <= ridx_s1;
							end
							last_q <= rdata_s1;
							eff_q  <= ridx_s1 + CW'(1);
						end
					end
					if (scan_done) begin
						if (kind_q == KIND_RELEASE) begin
							if (found_q) begin
								count_q      <= count_q - CW'(1);
								res_status_q <= STATUS_OK;
							end else begin
								res_status_q <= STATUS_WAS_FREE;
							end
							state_q <= ST_RESP;
						end else if (have_q && tail <= best_q && best_q == '0) begin
							res_status_q <= STATUS_FULL;
							pick_q       <= '0;
							state_q      <= ST_RESP;
						end else begin
							res_status_q <= STATUS_OK;
							rd_idx_q     <= count_q;
							state_q      <= ST_SHIFT;
							if (!have_q) begin
								pick_q <= '0;
								pos_q  <= '0;
							end else if (tail > best_q) begin
								pick_q <= nm1[AW-1:0];
								pos_q  <= eff_q;
							end
						end
					end
				end
				ST_SHIFT: begin
					if (rd_en) begin
						rd_idx_q <= rd_dec;
					end
					if (scan_done) begin
						count_q <= count_q + CW'(1);
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						status    <= res_status_q;
						if (kind_q == KIND_RELEASE) begin
							chosen_slot <= slot_q;
						end else begin
							chosen_slot <= 8'(pick_q);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The occupied list never holds more entries than MAX_SLOTS.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= 32'(MAX_SLOTS))
		else $error("occupied count exceeds MAX_SLOTS");

	// The list memory is written only while a request is being worked on.
	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_SCAN || state_q == ST_SHIFT))
		else $error("list memory written while idle");

	// An accepted transaction always starts with a scan of the list.
	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_SCAN))
		else $error("accepted transaction did not start a scan");

	// A full row reports slot zero.
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == STATUS_FULL) |-> (chosen_slot == 8'd0))
		else $error("full-row result carries a nonzero slot");

	// The occupancy only changes at the end of a scan or a shift.
	a_count_change: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> ($past(state_q) == ST_SCAN || $past(state_q) == ST_SHIFT))
		else $error("occupied count changed outside of a request");

endmodule
